// File: hw/rtl/zsbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsbf_pkg: types and constants for the zlib stored-block framer
// Input and result item layouts, item kinds and the fixed zlib constants.
// ----------------------------------------------------------------------------
package zsbf_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] total_length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;
    localparam logic [15:0] ADLER_MOD = 16'd65521;
    localparam logic [15:0] MAX_BLOCK = 16'd65535;

    // longest burst of result bytes that one item can cause
    localparam int unsigned BURST_DEPTH = 7;
    localparam int unsigned BURST_CW    = $clog2(BURST_DEPTH + 1);

endpackage

// File: hw/rtl/zlib_stored_block_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zlib_stored_block_framer: zlib stream of stored deflate blocks with Adler-32
// Wraps a byte stream in a zlib header, stored-block headers of at most
// MAX_BLOCK bytes and a big-endian Adler-32 trailer.
// ----------------------------------------------------------------------------
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+------------------------------------
//  input    | item_valid   | item_ready   | item   (kind, total_length, data_byte)
//  output   | result_valid | result_ready | result (out_byte, last)
//
//  An accepted item is worked in the cycle it arrives: the stream state and
//  the Adler sums update at that edge and its result bytes (none to seven)
//  load into the burst register. The burst register hands out one byte per
//  cycle while result_ready is high: a data byte yields one byte, the byte
//  that fills a block six (it carries the next block header), the final byte
//  five (Adler-32 trailer), a start item seven (six if empty), a stray byte none.
//  item_ready is high while the burst is empty or its final byte leaves in
//  this cycle; the output handshake alone sets the rate.
//  Reset clears the sums to 1/0, the stream and block counters to zero and
//  empties the burst register. A stalled output holds its byte unchanged.
// ----------------------------------------------------------------------------
module zlib_stored_block_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  zsbf_pkg::in_item_t item,
    output logic               result_valid,
    input  logic               result_ready,
    output zsbf_pkg::out_item_t result
);
    import zsbf_pkg::*;

    // Stream state
    logic [15:0] sum_low_reg,     sum_low_next;
    logic [15:0] sum_high_reg,    sum_high_next;
    logic [15:0] block_left_reg,  block_left_next;
    logic [31:0] stream_left_reg, stream_left_next;

    // Burst register: byte 0 goes out first
    logic [BURST_DEPTH-1:0][7:0] burst_reg,   burst_next;
    logic [BURST_CW-1:0]         count_reg,   count_next;
    logic                        trailer_reg, trailer_next;

    // Freshly built burst for the accepted item
    logic [BURST_DEPTH-1:0][7:0] load_bytes;
    logic [BURST_CW-1:0]         load_count;
    logic                        load_trailer;

    logic        accept;
    logic        take;
    logic [16:0] low_sum;
    logic [15:0] low_mod;
    logic [16:0] high_sum;
    logic [15:0] high_mod;
    logic [31:0] left_dec;
    logic [15:0] block_dec;
    logic [31:0] hdr_src;
    logic [15:0] hdr_len;
    logic        hdr_final;
    logic [39:0] hdr_bytes;

    // Stored-block header: BFINAL, LEN low/high, NLEN low/high
    function automatic logic [39:0] block_header(input logic [15:0] len,
                                                 input logic        bfinal);
        logic [15:0] nlen;
        nlen = ~len;
        return {nlen[15:8], nlen[7:0], len[15:8], len[7:0], 7'd0, bfinal};
    endfunction

    assign take         = result_valid && result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = (count_reg != '0);
    assign item_ready   = (count_reg == '0) ||
                          ((count_reg == BURST_CW'(1)) && result_ready);

    assign result.out_byte = burst_reg[0];
    assign result.last     = trailer_reg && (count_reg == BURST_CW'(1));

    // Adler-32 fold of the incoming byte
    always_comb
    begin
        low_sum  = {1'b0, sum_low_reg} + {9'd0, item.data_byte};
        low_mod  = (low_sum >= {1'b0, ADLER_MOD}) ?
                   16'(low_sum - {1'b0, ADLER_MOD}) : low_sum[15:0];
        high_sum = {1'b0, sum_high_reg} + {1'b0, low_mod};
        high_mod = (high_sum >= {1'b0, ADLER_MOD}) ?
                   16'(high_sum - {1'b0, ADLER_MOD}) : high_sum[15:0];
    end

    // Block header length from what remains of the stream
    always_comb
    begin
        left_dec  = stream_left_reg - 32'd1;
        block_dec = (block_left_reg != '0) ? (block_left_reg - 16'd1) : 16'd0;
        hdr_src   = (item.kind == KIND_START) ? item.total_length : left_dec;
        hdr_final = (hdr_src <= {16'd0, MAX_BLOCK});
        hdr_len   = hdr_final ? hdr_src[15:0] : MAX_BLOCK;
        hdr_bytes = block_header(hdr_len, hdr_final);
    end

    // Build the burst and the next state for the item at the input
    always_comb
    begin
        load_bytes       = '0;
        load_count       = '0;
        load_trailer     = 1'b0;
        sum_low_next     = sum_low_reg;
        sum_high_next    = sum_high_reg;
        block_left_next  = block_left_reg;
        stream_left_next = stream_left_reg;

        if (item.kind == KIND_START)
        begin
            // restart: abandon any stream in progress
            sum_low_next     = 16'd1;
            sum_high_next    = 16'd0;
            stream_left_next = item.total_length;
            load_bytes[0]    = ZLIB_CMF;
            load_bytes[1]    = ZLIB_FLG;
            if (item.total_length != '0)
            begin
                block_left_next = hdr_len;
                load_bytes[6:2] = hdr_bytes;
                load_count      = BURST_CW'(7);
            end
            else
            begin
                // empty stream: trailer of the initial sums
                block_left_next = 16'd0;
                load_bytes[2]   = 8'h00;
                load_bytes[3]   = 8'h00;
                load_bytes[4]   = 8'h00;
                load_bytes[5]   = 8'h01;
                load_count      = BURST_CW'(6);
                load_trailer    = 1'b1;
            end
        end
        else if (stream_left_reg != '0)
        begin
            sum_low_next     = low_mod;
            sum_high_next    = high_mod;
            stream_left_next = left_dec;
            block_left_next  = block_dec;
            load_bytes[0]    = item.data_byte;
            load_count       = BURST_CW'(1);
            if (left_dec == '0)
            begin
                // final byte: append Adler-32, big-endian
                block_left_next = 16'd0;
                load_bytes[1]   = high_mod[15:8];
                load_bytes[2]   = high_mod[7:0];
                load_bytes[3]   = low_mod[15:8];
                load_bytes[4]   = low_mod[7:0];
                load_count      = BURST_CW'(5);
                load_trailer    = 1'b1;
            end
            else if (block_dec == '0)
            begin
                // block full: open the next one
                block_left_next = hdr_len;
                load_bytes[5:1] = hdr_bytes;
                load_count      = BURST_CW'(6);
            end
        end
        // stray data byte: drop, no state change
    end

    // Burst register: load on accept, else shift on take
    always_comb
    begin
        burst_next   = burst_reg;
        count_next   = count_reg;
        trailer_next = trailer_reg;
        if (accept)
        begin
            burst_next   = load_bytes;
            count_next   = load_count;
            trailer_next = load_trailer;
        end
        else if (take)
        begin
            burst_next = {8'h00, burst_reg[BURST_DEPTH-1:1]};
            count_next = count_reg - BURST_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg     <= 16'd1;
            sum_high_reg    <= 16'd0;
            block_left_reg  <= 16'd0;
            stream_left_reg <= 32'd0;
            count_reg       <= '0;
            trailer_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sum_low_reg     <= sum_low_next;
                sum_high_reg    <= sum_high_next;
                block_left_reg  <= block_left_next;
                stream_left_reg <= stream_left_next;
            end
            count_reg   <= count_next;
            trailer_reg <= trailer_next;
        end
    end

    // Burst bytes carry no reset
    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

endmodule

// File: tb/zlib_stored_block_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zlib_stored_block_framer_tb: self-checking bench for the stored-block framer
// Pushes start and data items through the input channel with random idle
// cycles and output back-pressure. Every byte of the zlib stream is predicted
// and compared field by field with what leaves the block.
// ----------------------------------------------------------------------------
module zlib_stored_block_framer_tb;
    import zsbf_pkg::*;

    // BFINAL byte of a stored-block header (BTYPE stored is all zeros)
    localparam logic [7:0]  BFINAL_MORE   = 8'h00;
    localparam logic [7:0]  BFINAL_LAST   = 8'h01;

    localparam int unsigned DIR_ROWS      = 24;
    // items sent over the whole run, directed rows included
    localparam int unsigned ITEM_TARGET   = 270;
    localparam int unsigned IDLE_PCT      = 27;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned TIMEOUT_NS    = 2_000_000;

    // One row of the directed table. Rows marked known carry their expected
    // bytes written out by hand; the rest are checked against the predictor.
    typedef struct packed {
        in_item_t    item;
        logic        known;
        logic [2:0]  n_bytes;
        logic [55:0] bytes;     // first byte in the top lane
        logic        ends;      // final byte carries last
    } dir_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    // stream bytes still owed by the block, oldest first
    out_item_t   pending_bytes[$];
    // bytes the predictor produced for the item just accepted
    out_item_t   model_burst[$];
    out_item_t   want;

    // predictor state: Adler-32 sums and the stream/block byte counters
    int unsigned adler_a   = 1;
    int unsigned adler_b   = 0;
    int unsigned blk_left  = 0;
    int unsigned strm_left = 0;

    dir_row_t    dir_tab[DIR_ROWS];
    logic        steady    = 1'b0;
    int unsigned n_sent    = 0;
    int unsigned n_starts  = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors  = 0;

    zlib_stored_block_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Stream predictor
    // ------------------------------------------------------------------------
    function automatic void model_emit(logic [7:0] b, logic is_last);
        out_item_t r;
        r.out_byte  = b;
        r.last      = is_last;
        model_burst = {model_burst, r};
    endfunction

    // LEN is capped at one full block; BFINAL only when it covers the rest
    function automatic void model_block_header();
        logic [15:0] len;
        logic [15:0] nlen;
        len  = (strm_left > MAX_BLOCK) ? MAX_BLOCK : strm_left[15:0];
        nlen = ~len;
        model_emit((len == strm_left) ? BFINAL_LAST : BFINAL_MORE, 1'b0);
        model_emit(len[7:0], 1'b0);
        model_emit(len[15:8], 1'b0);
        model_emit(nlen[7:0], 1'b0);
        model_emit(nlen[15:8], 1'b0);
        blk_left = len;
    endfunction

    // Adler-32 goes out big-endian: B high, B low, A high, A low
    function automatic void model_adler();
        model_emit(adler_b[15:8], 1'b0);
        model_emit(adler_b[7:0], 1'b0);
        model_emit(adler_a[15:8], 1'b0);
        model_emit(adler_a[7:0], 1'b1);
    endfunction

    function automatic void model_step(in_item_t it);
        model_burst.delete();
        if (it.kind == KIND_START) begin
            // a start always abandons whatever stream was open
            adler_a   = 1;
            adler_b   = 0;
            blk_left  = 0;
            strm_left = it.total_length;
            model_emit(ZLIB_CMF, 1'b0);
            model_emit(ZLIB_FLG, 1'b0);
            if (strm_left != 0)
                model_block_header();
            else
                model_adler();
        end else if (strm_left != 0) begin
            model_emit(it.data_byte, 1'b0);
            adler_a += it.data_byte;
            if (adler_a >= ADLER_MOD)
                adler_a -= ADLER_MOD;
            adler_b += adler_a;
            if (adler_b >= ADLER_MOD)
                adler_b -= ADLER_MOD;
            strm_left--;
            if (blk_left != 0)
                blk_left--;
            if (strm_left == 0) begin
                blk_left = 0;
                model_adler();
            end else if (blk_left == 0) begin
                model_block_header();
            end
        end
        // otherwise a stray byte: drop it, nothing comes out
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic dir_row_t known_row(logic kind, logic [31:0] len, logic [7:0] b,
                                           int n, logic [55:0] bytes, logic ends);
        dir_row_t r;
        r.item.kind         = kind;
        r.item.total_length = len;
        r.item.data_byte    = b;
        r.known             = 1'b1;
        r.n_bytes           = n[2:0];
        r.bytes             = bytes;
        r.ends              = ends;
        return r;
    endfunction

    function automatic dir_row_t model_row(logic kind, logic [31:0] len, logic [7:0] b);
        dir_row_t r;
        r                   = '0;
        r.item.kind         = kind;
        r.item.total_length = len;
        r.item.data_byte    = b;
        return r;
    endfunction

    // unused fields carry random junk so that every input bit toggles
    function automatic in_item_t start_item(logic [31:0] len);
        in_item_t it;
        it.kind         = KIND_START;
        it.total_length = len;
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    function automatic in_item_t data_item(logic [7:0] b);
        in_item_t it;
        it.kind         = KIND_DATA;
        it.total_length = $urandom;
        it.data_byte    = b;
        return it;
    endfunction

    // Idle at random cycle by cycle first (unless in a steady stretch), then
    // hold the item on the channel until it is taken. Valid is lowered only
    // when idling, so back-to-back items keep it high without a second
    // assignment in a step.
    task automatic send_item(input in_item_t it, input bit use_model);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        model_step(it);
        n_sent++;
        if (it.kind == KIND_START)
            n_starts++;
        if (use_model)
            foreach (model_burst[k])
                pending_bytes = {pending_bytes, model_burst[k]};
    endtask

    // withdraw the sender and wait until every owed byte has come out
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, compare each byte with the oldest
    // expectation. Sample before the edge's updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            n_checked++;
            if (pending_bytes.size() == 0) begin
                n_errors++;
                $display("%0t: stream byte with none expected: expected none, got %02h last %0b",
                         $time, result.out_byte, result.last);
            end else begin
                want = pending_bytes.pop_front();
                if (result.out_byte !== want.out_byte) begin
                    n_errors++;
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_byte, result.out_byte);
                end
                if (result.last !== want.last) begin
                    n_errors++;
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, result.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned len;
        int unsigned cut;
        int unsigned pick;
        out_item_t   typed_byte;

        // Directed table: stray bytes, empty and one-byte streams, length
        // extremes, abandoned streams and toggling length patterns.
        dir_tab[0]  = known_row(KIND_DATA,  32'd0,          8'hFF, 0, 56'h0, 1'b0);
        dir_tab[1]  = known_row(KIND_START, 32'd0,          8'h00, 6,
                                56'h78_01_00_00_00_01_00, 1'b1);
        dir_tab[2]  = known_row(KIND_START, 32'd1,          8'h00, 7,
                                56'h78_01_01_01_00_FE_FF, 1'b0);
        dir_tab[3]  = known_row(KIND_DATA,  32'd0,          8'hFF, 5,
                                56'hFF_01_00_01_00_00_00, 1'b1);
        dir_tab[4]  = known_row(KIND_DATA,  32'd0,          8'h00, 0, 56'h0, 1'b0);
        dir_tab[5]  = model_row(KIND_START, 32'd3,          8'h00);
        dir_tab[6]  = model_row(KIND_DATA,  32'd0,          8'h00);
        dir_tab[7]  = model_row(KIND_DATA,  32'd0,          8'h80);
        dir_tab[8]  = model_row(KIND_DATA,  32'd0,          8'h7F);
        dir_tab[9]  = known_row(KIND_START, 32'hFFFF_FFFF,  8'h00, 7,
                                56'h78_01_00_FF_FF_00_00, 1'b0);
        dir_tab[10] = model_row(KIND_DATA,  32'd0,          8'h55);
        dir_tab[11] = known_row(KIND_START, 32'd65535,      8'h00, 7,
                                56'h78_01_01_FF_FF_00_00, 1'b0);
        dir_tab[12] = model_row(KIND_DATA,  32'd0,          8'hAA);
        dir_tab[13] = known_row(KIND_START, 32'd65536,      8'h00, 7,
                                56'h78_01_00_FF_FF_00_00, 1'b0);
        dir_tab[14] = model_row(KIND_START, 32'h8000_0000,  8'h00);
        dir_tab[15] = known_row(KIND_START, 32'd2,          8'h00, 7,
                                56'h78_01_01_02_00_FD_FF, 1'b0);
        dir_tab[16] = model_row(KIND_DATA,  32'd0,          8'h01);
        dir_tab[17] = model_row(KIND_DATA,  32'd0,          8'hFE);
        dir_tab[18] = known_row(KIND_DATA,  32'd0,          8'h33, 0, 56'h0, 1'b0);
        dir_tab[19] = known_row(KIND_START, 32'd0,          8'h00, 6,
                                56'h78_01_00_00_00_01_00, 1'b1);
        dir_tab[20] = model_row(KIND_START, 32'h5555_5555,  8'h00);
        dir_tab[21] = model_row(KIND_START, 32'hAAAA_AAAA,  8'h00);
        dir_tab[22] = model_row(KIND_START, 32'd1,          8'h00);
        dir_tab[23] = model_row(KIND_DATA,  32'd0,          8'h00);

        // hold reset low at first, then release it on an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: known rows queue their hand-written bytes instead
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_tab[i].item, !dir_tab[i].known);
            if (dir_tab[i].known)
                for (int k = 0; k < dir_tab[i].n_bytes; k++) begin
                    typed_byte.out_byte = dir_tab[i].bytes[55 - 8 * k -: 8];
                    typed_byte.last     = dir_tab[i].ends && (k == dir_tab[i].n_bytes - 1);
                    pending_bytes       = {pending_bytes, typed_byte};
                end
        end

        // let the block run dry once before the random part
        drain();

        // Random part: mostly complete streams with random content, some cut
        // short by a new start, plus stray bytes and huge abandoned streams.
        // A stretch in the middle runs with no idling on either side.
        while (n_sent < ITEM_TARGET) begin
            steady <= (n_sent >= 120 && n_sent < 190);
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(99) < 85) ? $urandom_range(0, 12)
                                                : $urandom_range(13, 40);
                cut = ($urandom_range(9) == 0) ? $urandom_range(0, len) : len;
                send_item(start_item(len), 1'b1);
                repeat (cut) send_item(data_item(8'($urandom)), 1'b1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) send_item(data_item(8'($urandom)), 1'b1);
            end else begin
                send_item(start_item($urandom), 1'b1);
                repeat ($urandom_range(0, 5)) send_item(data_item(8'($urandom)), 1'b1);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run summary: %0d items sent (%0d stream starts), %0d stream bytes checked.",
                 n_sent, n_starts, n_checked);
        $display("Streams ranged from empty to a few dozen bytes, with length extremes,");
        $display("stray bytes and abandoned streams under random and steady flow.");
        if (n_errors == 0)
            $display("zlib_stored_block_framer regression: pass");
        else
            $display("zlib_stored_block_framer regression: fail");
        $finish;
    end

    // watchdog: give up well past the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("zlib_stored_block_framer regression: fail");
        $finish;
    end

endmodule
